FILE: src/rhc_pkg.sv
// shared types and constants for the rgb to hsv converter
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  // quotient bits, one per division cell
  localparam int unsigned QUOT_W   = 13;
  // dividend width fed to the division chain
  localparam int unsigned DVD_W    = 21;
  // divisor width (twice an 8-bit channel)
  localparam int unsigned DIV_W    = 9;
  localparam int unsigned NUM_CELLS = QUOT_W;

  // hue sector constants in degrees
  localparam logic [8:0] HUE_STEP     = 9'd60;
  localparam logic [8:0] HUE_OFF_RED  = 9'd0;
  localparam logic [8:0] HUE_OFF_GRN  = 9'd120;
  localparam logic [8:0] HUE_OFF_BLU  = 9'd240;
  localparam logic [8:0] HUE_OFF_WRAP = 9'd360;

  // one restoring division in flight
  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [QUOT_W-1:0] work;
    logic [DIV_W-1:0]  div;
  } lane_t;

  // everything that travels with one item down the chain
  typedef struct packed {
    lane_t      hue;
    lane_t      sat;
    logic [7:0] value;
    logic [7:0] alpha;
  } stage_t;

endpackage

`default_nettype wire

FILE: src/rhc_if.sv
// valid/ready channel interfaces for rgb pixels in and hsv pixels out
`timescale 1ns / 1ps
`default_nettype none

interface rhc_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rhc_hsv_if;
  logic        valid;
  logic        ready;
  logic [8:0]  hue_deg;
  logic [12:0] saturation_q12;
  logic [7:0]  value_level;
  logic [7:0]  alpha_out;

  modport source (output valid, hue_deg, saturation_q12, value_level, alpha_out, input ready);
  modport sink   (input valid, hue_deg, saturation_q12, value_level, alpha_out, output ready);
endinterface

`default_nettype wire

FILE: src/rhc_front.sv
// front stage: max, min, sector and the two dividends for the division chain
`timescale 1ns / 1ps
`default_nettype none

module rhc_front import rhc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_valid,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic [7:0] alpha,
  output stage_t          out_stage,
  output logic            out_valid
);

  logic [7:0]       mx;
  logic [7:0]       mn;
  logic [7:0]       delta;
  logic [8:0]       diff;
  logic [8:0]       off;
  logic [18:0]      num;
  logic [DVD_W-1:0] dvd_h;
  logic [DVD_W-1:0] dvd_s;
  logic [DIV_W-1:0] div_h;
  logic [DIV_W-1:0] div_s;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    // sector priority red, green, blue; diff is signed two's complement
    if (red == mx) begin
      diff = {1'b0, green} - {1'b0, blue};
      off  = (green < blue) ? HUE_OFF_WRAP : HUE_OFF_RED;
    end else if (green == mx) begin
      diff = {1'b0, blue} - {1'b0, red};
      off  = HUE_OFF_GRN;
    end else begin
      diff = {1'b0, red} - {1'b0, green};
      off  = HUE_OFF_BLU;
    end

    // numerator is never negative, so mod 2^19 arithmetic is exact
    num = 19'(off) * 19'(delta) + 19'(HUE_STEP) * {{10{diff[8]}}, diff};

    // round half up: (2n + d) / (2d)
    dvd_h = DVD_W'({num[16:0], 1'b0}) + DVD_W'(delta);
    dvd_s = {delta, 13'd0} + DVD_W'(mx);

    // zero divisor only with zero dividend; any nonzero divisor gives 0
    div_h = (delta == 8'd0) ? 9'd2 : {delta, 1'b0};
    div_s = (mx == 8'd0) ? 9'd2 : {mx, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage.hue.rem  <= DIV_W'(dvd_h[DVD_W-1:QUOT_W]);
      out_stage.hue.work <= dvd_h[QUOT_W-1:0];
      out_stage.hue.div  <= div_h;
      out_stage.sat.rem  <= DIV_W'(dvd_s[DVD_W-1:QUOT_W]);
      out_stage.sat.work <= dvd_s[QUOT_W-1:0];
      out_stage.sat.div  <= div_s;
      out_stage.value    <= mx;
      out_stage.alpha    <= alpha;
    end
  end

endmodule

`default_nettype wire

FILE: src/rhc_cell.sv
// one division cell: a restoring step for the hue and saturation quotients
`timescale 1ns / 1ps
`default_nettype none

module rhc_cell import rhc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire stage_t in_stage,
  output stage_t      out_stage,
  output logic        out_valid
);

  logic [DIV_W:0] sh_h;
  logic [DIV_W:0] sh_s;
  logic           ge_h;
  logic           ge_s;
  stage_t         step;

  always_comb begin
    step = in_stage;

    // shift the next dividend bit into the remainder and try the subtract
    sh_h = {in_stage.hue.rem, in_stage.hue.work[QUOT_W-1]};
    ge_h = sh_h >= {1'b0, in_stage.hue.div};
    step.hue.rem  = ge_h ? DIV_W'(sh_h - {1'b0, in_stage.hue.div}) : sh_h[DIV_W-1:0];
    step.hue.work = {in_stage.hue.work[QUOT_W-2:0], ge_h};

    sh_s = {in_stage.sat.rem, in_stage.sat.work[QUOT_W-1]};
    ge_s = sh_s >= {1'b0, in_stage.sat.div};
    step.sat.rem  = ge_s ? DIV_W'(sh_s - {1'b0, in_stage.sat.div}) : sh_s[DIV_W-1:0];
    step.sat.work = {in_stage.sat.work[QUOT_W-2:0], ge_s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= step;
    end
  end

endmodule

`default_nettype wire

FILE: src/rgb_to_hsv_converter.sv
// rgb to hsv converter: front stage followed by a row of division cells
// an item passes the front register, then each cell register in turn
// one item per cycle unless held; the 13-cell quotient chain sets the depth
// the whole chain holds while a finished result waits for out ready
// reset clears only the valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter import rhc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  rhc_rgb_if.sink   pix_in,
  rhc_hsv_if.source pix_out
);

  stage_t stg [0:NUM_CELLS];
  logic   vld [0:NUM_CELLS];
  logic   en;

  // the chain moves unless the last cell holds a result nobody takes
  assign en           = !vld[NUM_CELLS] || pix_out.ready;
  assign pix_in.ready = en;

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pix_in.valid),
    .red       (pix_in.red_in),
    .green     (pix_in.green_in),
    .blue      (pix_in.blue_in),
    .alpha     (pix_in.alpha_in),
    .out_stage (stg[0]),
    .out_valid (vld[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_stage  (stg[i]),
      .out_stage (stg[i+1]),
      .out_valid (vld[i+1])
    );
  end

  assign pix_out.valid          = vld[NUM_CELLS];
  assign pix_out.hue_deg        = stg[NUM_CELLS].hue.work[8:0];
  assign pix_out.saturation_q12 = stg[NUM_CELLS].sat.work;
  assign pix_out.value_level    = stg[NUM_CELLS].value;
  assign pix_out.alpha_out      = stg[NUM_CELLS].alpha;

endmodule

`default_nettype wire

FILE: tb/rgb_to_hsv_converter_tb.sv
// self-checking testbench for the rgb to hsv converter with random handshake gaps
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgb_pix_t;

  typedef struct packed {
    logic [8:0]  hue;
    logic [12:0] sat;
    logic [7:0]  value;
    logic [7:0]  alpha;
  } hsv_pix_t;

  localparam int RANDOM_PIXELS = 1450;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 30;

  logic clk;
  logic rst;

  rhc_rgb_if pix_in ();
  rhc_hsv_if pix_out ();

  rgb_to_hsv_converter i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  rgb_pix_t pending_pixels[$];
  hsv_pix_t expected_hsv[$];

  int   send_gap;
  int   send_calm;
  int   recv_stall;
  int   recv_calm;
  int   sent_count;
  int   error_count;
  logic long_hold;

  // integer hsv conversion, hue rounded half up, saturation in q1.12
  function automatic hsv_pix_t convert_pixel(rgb_pix_t p);
    int r, g, b, hi, lo, spread, num;
    hsv_pix_t h;
    r = p.red;
    g = p.green;
    b = p.blue;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    spread = hi - lo;
    h.hue = '0;
    if (spread != 0) begin
      // tied maxima resolve red first, then green
      if (r == hi) begin
        num = 60 * (g - b);
        if (g < b) num += 360 * spread;
      end else if (g == hi) begin
        num = 60 * (b - r) + 120 * spread;
      end else begin
        num = 60 * (r - g) + 240 * spread;
      end
      h.hue = 9'((2 * num + spread) / (2 * spread));
    end
    h.sat   = (hi == 0) ? '0 : 13'((spread * 8192 + hi) / (2 * hi));
    h.value = 8'(hi);
    h.alpha = p.alpha;
    return h;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void add_pixel(int r, int g, int b, int a);
    rgb_pix_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.alpha = 8'(a);
    pending_pixels.push_back(p);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        rgb_pix_t p;
        p = {pix_in.red_in, pix_in.green_in, pix_in.blue_in, pix_in.alpha_in};
        expected_hsv.push_back(convert_pixel(p));
        sent_count++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          pix_in.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          rgb_pix_t nxt;
          nxt = pending_pixels.pop_front();
          pix_in.red_in   <= nxt.red;
          pix_in.green_in <= nxt.green;
          pix_in.blue_in  <= nxt.blue;
          pix_in.alpha_in <= nxt.alpha;
          pix_in.valid    <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        hsv_pix_t got, want;
        got = {pix_out.hue_deg, pix_out.saturation_q12, pix_out.value_level,
               pix_out.alpha_out};
        if (expected_hsv.size() == 0) begin
          $display("%0t: unexpected item, hue %0d sat %0d value %0d alpha %0d",
                   $time, got.hue, got.sat, got.value, got.alpha);
          error_count++;
        end else begin
          want = expected_hsv.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected hue %0d sat %0d value %0d alpha %0d",
                     $time, want.hue, want.sat, want.value, want.alpha);
            $display("%0t:           actual   hue %0d sat %0d value %0d alpha %0d",
                     $time, got.hue, got.sat, got.value, got.alpha);
            error_count++;
          end
        end
        recv_stall = pick_gap(recv_calm);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      pix_out.ready <= !long_hold && (recv_stall == 0);
    end
  end

  // long output stalls while the sender keeps offering, so the chain backs up
  initial begin
    long_hold = 1'b0;
    for (int k = 1; k <= 2; k++) begin
      wait (sent_count >= 400 * k);
      @(posedge clk);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  initial begin
    #2000000;
    $display("rgb_to_hsv_converter_tb: FAIL");
    $finish;
  end

  initial begin
    int base;
    int ch[3];
    rst              = 1'b1;
    pix_in.valid     = 1'b0;
    pix_in.red_in    = '0;
    pix_in.green_in  = '0;
    pix_in.blue_in   = '0;
    pix_in.alpha_in  = '0;
    pix_out.ready    = 1'b0;
    send_calm        = 0;
    recv_calm        = 0;
    sent_count       = 0;
    error_count      = 0;

    // directed pixels
    add_pixel(0, 0, 0, 0);          // black
    add_pixel(255, 255, 255, 255);  // white
    add_pixel(128, 128, 128, 85);   // gray
    add_pixel(1, 1, 1, 170);
    add_pixel(255, 0, 0, 255);
    add_pixel(0, 255, 0, 0);
    add_pixel(0, 0, 255, 255);
    add_pixel(255, 255, 0, 1);      // red and green tie
    add_pixel(0, 255, 255, 254);    // green and blue tie
    add_pixel(255, 0, 255, 128);    // red and blue tie
    add_pixel(255, 0, 1, 127);      // rounds up to 360
    add_pixel(255, 0, 2, 64);
    add_pixel(120, 1, 0, 32);       // hue exactly half a degree
    add_pixel(200, 50, 100, 16);    // red sector, wrapped
    add_pixel(200, 100, 50, 8);
    add_pixel(1, 0, 0, 4);
    add_pixel(0, 1, 0, 2);
    add_pixel(0, 0, 1, 191);
    add_pixel(1, 1, 0, 223);
    add_pixel(0, 1, 1, 239);
    add_pixel(3, 1, 2, 247);
    add_pixel(254, 255, 253, 251);
    add_pixel(10, 200, 30, 253);
    add_pixel(90, 60, 240, 93);

    // random pixels, a share of them near gray
    repeat (RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) == 0) begin
        base = $urandom_range(0, 255);
        foreach (ch[i]) begin
          ch[i] = base + $urandom_range(0, 6) - 3;
          if (ch[i] < 0) ch[i] = 0;
          if (ch[i] > 255) ch[i] = 255;
        end
        add_pixel(ch[0], ch[1], ch[2], $urandom_range(0, 255));
      end else begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_pixels.size() == 0 && !pix_in.valid);
    wait (expected_hsv.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("rgb_to_hsv_converter_tb: PASS");
    end else begin
      $display("rgb_to_hsv_converter_tb: FAIL");
    end
    $finish;
  end

endmodule
